/* sv/fwcs_pkg.sv */
// Shared types and constants of the fair wakeup CPU selector.
// Used by every module of the block; depends on nothing.
package fwcs_pkg;

  localparam int MAX_CPUS       = 64;
  localparam int CAPACITY_SCALE = 1024;

  localparam int CPU_W   = 6;
  localparam int UTIL_W  = 11;
  localparam int LOC_W   = 2;
  localparam int FLAGS_W = 6;
  localparam int BIAS_W  = 4;

  // Signed working width of a score: four loads below zero, three bonuses above capacity.
  localparam int SCORE_W = 15;

  localparam int BIAS_MAX      = 8;
  localparam int AFFINE_MULT   = 8;
  localparam int BONUS_SHIFT   = $clog2(CAPACITY_SCALE) - 5;
  localparam int BUSY_MARGIN   = CAPACITY_SCALE >> 3;
  localparam int OUT_SCORE_W   = 11;
  localparam int BIAS_RESET    = 4;

  // Wakeup flag bit positions.
  localparam int WF_TTWU     = 0;
  localparam int WF_EXEC     = 1;
  localparam int WF_SYNC     = 2;
  localparam int WF_AFFINE   = 3;
  localparam int WF_QUEUED   = 4;
  localparam int WF_LLC_KNOWN = 5;

  // Locality bit positions.
  localparam int LOC_SMT = 0;
  localparam int LOC_LLC = 1;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMT_BIAS = 2'd0,
    CFG_LLC_BIAS = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CPU_W-1:0]   cpu_id;
    logic [UTIL_W-1:0]  cpu_capacity;
    logic [UTIL_W-1:0]  cfs_util;
    logic [UTIL_W-1:0]  rt_util;
    logic [UTIL_W-1:0]  dl_util;
    logic [LOC_W-1:0]   locality;
    logic [UTIL_W-1:0]  task_util;
    logic [CPU_W-1:0]   prior_cpu;
    logic [CPU_W-1:0]   waker_cpu;
    logic [FLAGS_W-1:0] wake_bits;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [CPU_W-1:0]       chosen_cpu;
    logic [OUT_SCORE_W-1:0] best_score;
  } out_item_t;

  // One classified candidate on its way from the front end to the back end.
  typedef struct packed {
    logic                      first;
    logic                      last;
    logic                      scored;
    logic                      self_hit;
    logic                      sync_ret;
    logic [CPU_W-1:0]          cpu;
    logic [CPU_W-1:0]          prev;
    logic [CPU_W-1:0]          self;
    logic signed [SCORE_W-1:0] score;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic logic [BIAS_W-1:0] clamp_bias(input logic [BIAS_W-1:0] v);
    clamp_bias = (v > BIAS_W'(BIAS_MAX)) ? BIAS_W'(BIAS_MAX) : v;
  endfunction

endpackage

/* sv/fwcs_front.sv */
// Front end: takes candidate records, scores them and pushes them into the queue.
// Depends on fwcs_pkg.
module fwcs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fwcs_pkg::in_item_t            in_data,
  input  logic [fwcs_pkg::BIAS_W-1:0]   smt_bias,
  input  logic [fwcs_pkg::BIAS_W-1:0]   llc_bias,
  input  fwcs_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output fwcs_pkg::q_entry_t            q_wdata
);
  import fwcs_pkg::*;

  logic in_req_r, in_req_nxt;
  logic ttwu, exec_w, sync_w, affine, queued, llc_known;
  logic is_prev, is_self, in_range, apply;
  logic [SCORE_W-1:0] load_a, load_b, load_sum, bonus;
  logic [SCORE_W-1:0] aff_bonus, smt_bonus, llc_bonus;
  logic signed [SCORE_W-1:0] raw, score;

  always_comb begin
    ttwu      = in_data.wake_bits[WF_TTWU];
    exec_w    = in_data.wake_bits[WF_EXEC];
    sync_w    = in_data.wake_bits[WF_SYNC];
    affine    = ttwu && in_data.wake_bits[WF_AFFINE];
    queued    = in_data.wake_bits[WF_QUEUED];
    llc_known = in_data.wake_bits[WF_LLC_KNOWN];
    is_prev   = (in_data.cpu_id == in_data.prior_cpu);
    is_self   = (in_data.cpu_id == in_data.waker_cpu);
    in_range  = ({1'b0, in_data.cpu_id} < (CPU_W + 1)'(MAX_CPUS));

    // The task's own load does not count against its previous CPU while it is queued.
    load_a   = SCORE_W'(in_data.cfs_util) + SCORE_W'(in_data.rt_util);
    load_b   = SCORE_W'(in_data.dl_util) +
               ((queued && is_prev) ? '0 : SCORE_W'(in_data.task_util));
    load_sum = load_a + load_b;
    raw      = $signed(SCORE_W'(in_data.cpu_capacity) - load_sum);

    aff_bonus = (affine && (is_self || is_prev)) ?
                (SCORE_W'(AFFINE_MULT) << BONUS_SHIFT) : '0;
    smt_bonus = (!affine && ttwu && in_data.locality[LOC_SMT]) ?
                (SCORE_W'(clamp_bias(smt_bias)) << BONUS_SHIFT) : '0;
    llc_bonus = (llc_known && in_data.locality[LOC_LLC]) ?
                (SCORE_W'(clamp_bias(llc_bias)) << BONUS_SHIFT) : '0;
    bonus     = aff_bonus + smt_bonus + llc_bonus;

    apply = !exec_w && (raw >= $signed(SCORE_W'(BUSY_MARGIN)));
    score = apply ? $signed(raw + bonus) : raw;

    q_wdata.first    = !in_req_r;
    q_wdata.last     = in_data.last;
    q_wdata.scored   = in_range;
    q_wdata.self_hit = in_range && is_self;
    q_wdata.sync_ret = ttwu && sync_w;
    q_wdata.cpu      = in_data.cpu_id;
    q_wdata.prev     = in_data.prior_cpu;
    q_wdata.self     = in_data.waker_cpu;
    q_wdata.score    = score;
  end

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    in_req_nxt = in_req_r;
    if (q_push) begin
      in_req_nxt = !in_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_req_r <= 1'b0;
    end else begin
      in_req_r <= in_req_nxt;
    end
  end

endmodule

/* sv/fwcs_queue.sv */
// Short queue of scored candidates between the front and back ends.
// Depends on fwcs_pkg.
module fwcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fwcs_pkg::q_entry_t  wdata,
  input  logic                pop,
  output fwcs_pkg::q_entry_t  rdata,
  output fwcs_pkg::q_stat_t   stat
);
  import fwcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.valid = (cnt_r != '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == CNT_W'($past(cnt_r) - 1'b1))
    else $error("queue count did not drop after a lone pop");

endmodule

/* sv/fwcs_back.sv */
// Back end: running best-score selection and the result register.
// Depends on fwcs_pkg.
module fwcs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fwcs_pkg::q_stat_t   q_stat,
  input  fwcs_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output fwcs_pkg::out_item_t out_data
);
  import fwcs_pkg::*;

  logic [CPU_W-1:0]          best_cpu_r, best_cpu_nxt, base_cpu;
  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt, base_score;
  logic                      seen_r, seen_nxt, base_seen;
  logic                      out_valid_r, out_valid_nxt, out_free;
  out_item_t                 out_data_r, out_data_nxt;

  assign out_free = !out_valid_r || out_ready;
  // Candidates that close no request never need the result register.
  assign q_pop    = q_stat.valid && (!q_rdata.last || out_free);

  always_comb begin
    base_cpu   = q_rdata.first ? q_rdata.prev : best_cpu_r;
    base_score = q_rdata.first ? '0 : best_score_r;
    base_seen  = q_rdata.first ? 1'b0 : seen_r;

    best_cpu_nxt   = best_cpu_r;
    best_score_nxt = best_score_r;
    seen_nxt       = seen_r;
    if (q_pop) begin
      best_cpu_nxt   = base_cpu;
      best_score_nxt = base_score;
      seen_nxt       = base_seen || q_rdata.self_hit;
      if (q_rdata.scored && (q_rdata.score > base_score)) begin
        best_cpu_nxt   = q_rdata.cpu;
        best_score_nxt = q_rdata.score;
      end
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (q_pop && q_rdata.last) begin
      out_valid_nxt = 1'b1;
      if (q_rdata.sync_ret && seen_nxt) begin
        out_data_nxt.chosen_cpu = q_rdata.self;
        out_data_nxt.best_score = '0;
      end else begin
        out_data_nxt.chosen_cpu = best_cpu_nxt;
        // The running best never drops below zero, so only the top needs clipping.
        out_data_nxt.best_score = (|best_score_nxt[SCORE_W-2:OUT_SCORE_W]) ?
                                  '1 : best_score_nxt[OUT_SCORE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_cpu_r   <= '0;
      best_score_r <= '0;
      seen_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      best_cpu_r   <= best_cpu_nxt;
      best_score_r <= best_score_nxt;
      seen_r       <= seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_rdata.last |=> out_valid_r)
    else $error("closing candidate left no result");

  a_best_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !best_score_r[SCORE_W-1])
    else $error("running best score went negative");

endmodule

/* sv/fair_wakeup_cpu_selector_core.sv */
// Top level of the fair wakeup CPU selector: configuration registers and wiring
// of front end, candidate queue and back end. Depends on fwcs_pkg and its submodules.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid/in_ready    fwcs_pkg::in_item_t, one candidate CPU
//   out_*        output     out_valid/out_ready  fwcs_pkg::out_item_t, one per request
//   cfg_*        input      cfg_valid/cfg_ready  cfg_index (register), cfg_data (4 bits)
//
// Throughput is one candidate per cycle while in_ready is high and, for a closing candidate,
// the result register is free: the front end scores a record in the cycle it is accepted
// and the back end folds one queued record per cycle into the running maximum. A result is
// registered on out_valid once its closing candidate and all candidates ahead are folded in.
// When the result register is held by out_ready low, the queue absorbs up to QUEUE_DEPTH
// candidates before in_ready falls; non-closing candidates at the head keep draining.
// Reset is synchronous and active low; it sets both bias registers to four and clears
// the queue, the request tracking and the result register. There is no clearing pass.
module fair_wakeup_cpu_selector_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fwcs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fwcs_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fwcs_pkg::BIAS_W-1:0]      cfg_data
);
  import fwcs_pkg::*;

  logic [BIAS_W-1:0] smt_bias_r, smt_bias_nxt;
  logic [BIAS_W-1:0] llc_bias_r, llc_bias_nxt;
  logic              cfg_write;

  q_stat_t  q_stat;
  q_entry_t q_wdata, q_rdata;
  logic     q_push, q_pop;

  // Configuration writes go straight into the bias registers, so the port is always ready.
  // Writes to an index past the register list are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    smt_bias_nxt = smt_bias_r;
    llc_bias_nxt = llc_bias_r;
    if (cfg_write) begin
      if (cfg_index == CFG_SMT_BIAS) begin
        smt_bias_nxt = cfg_data;
      end else if (cfg_index == CFG_LLC_BIAS) begin
        llc_bias_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smt_bias_r <= BIAS_W'(BIAS_RESET);
      llc_bias_r <= BIAS_W'(BIAS_RESET);
    end else begin
      smt_bias_r <= smt_bias_nxt;
      llc_bias_r <= llc_bias_nxt;
    end
  end

  // Front end: scores each candidate and marks where a request starts and ends.
  fwcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .smt_bias (smt_bias_r),
    .llc_bias (llc_bias_r),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Queue that lets the front end keep accepting while a result waits to be taken.
  fwcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: keeps the best candidate of the open request and issues the result.
  fwcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/cpu_choice_checker.sv */
// Checker for the fair wakeup CPU selector: watches all three channels, predicts the chosen CPU.
// Compares each result against its prediction. Depends on fwcs_pkg only.
module cpu_choice_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  fwcs_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  fwcs_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fwcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwcs_pkg::BIAS_W-1:0]    cfg_data,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fwcs_pkg::*;

  localparam int BONUS_UNIT = CAPACITY_SCALE >> 5;
  localparam int SCORE_CEIL = (1 << OUT_SCORE_W) - 1;

  logic [BIAS_W-1:0] smt_weight;
  logic [BIAS_W-1:0] llc_weight;
  logic [CPU_W-1:0]  lead_cpu;
  int                lead_score;
  bit                self_listed;
  bit                open_request;
  out_item_t         expected_choices[$];

  // Folds one candidate into the running best and queues a choice on the closing one.
  task automatic fold_candidate(input in_item_t c);
    int        score;
    int        smt_eff;
    int        llc_eff;
    int        clipped;
    logic      ttwu;
    logic      exec_wake;
    logic      sync_wake;
    logic      affine;
    logic      queued;
    logic      llc_known;
    out_item_t choice;
    ttwu      = c.wake_bits[WF_TTWU];
    exec_wake = c.wake_bits[WF_EXEC];
    sync_wake = c.wake_bits[WF_SYNC];
    affine    = ttwu && c.wake_bits[WF_AFFINE];
    queued    = c.wake_bits[WF_QUEUED];
    llc_known = c.wake_bits[WF_LLC_KNOWN];
    smt_eff   = (int'(smt_weight) > BIAS_MAX) ? BIAS_MAX : int'(smt_weight);
    llc_eff   = (int'(llc_weight) > BIAS_MAX) ? BIAS_MAX : int'(llc_weight);

    if (!open_request) begin
      open_request = 1'b1;
      lead_cpu     = c.prior_cpu;
      lead_score   = 0;
      self_listed  = 1'b0;
    end

    if (int'(c.cpu_id) < MAX_CPUS) begin
      score = int'(c.cpu_capacity) - int'(c.cfs_util) - int'(c.rt_util) - int'(c.dl_util);
      if (!(queued && c.cpu_id == c.prior_cpu)) begin
        score -= int'(c.task_util);
      end
      if (c.cpu_id == c.waker_cpu) begin
        self_listed = 1'b1;
      end
      if (!exec_wake && score >= BUSY_MARGIN) begin
        if (affine && (c.cpu_id == c.waker_cpu || c.cpu_id == c.prior_cpu)) begin
          score += BONUS_UNIT * AFFINE_MULT;
        end
        if (!affine && ttwu && c.locality[LOC_SMT]) begin
          score += BONUS_UNIT * smt_eff;
        end
        if (llc_known && c.locality[LOC_LLC]) begin
          score += BONUS_UNIT * llc_eff;
        end
      end
      if (score > lead_score) begin
        lead_score = score;
        lead_cpu   = c.cpu_id;
      end
    end

    if (c.last) begin
      open_request = 1'b0;
      if (ttwu && sync_wake && self_listed) begin
        choice.chosen_cpu = c.waker_cpu;
        choice.best_score = '0;
      end else begin
        clipped = (lead_score < 0) ? 0 : lead_score;
        clipped = (clipped > SCORE_CEIL) ? SCORE_CEIL : clipped;
        choice.chosen_cpu = lead_cpu;
        choice.best_score = OUT_SCORE_W'(clipped);
      end
      expected_choices.push_back(choice);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      smt_weight   = BIAS_W'(BIAS_RESET);
      llc_weight   = BIAS_W'(BIAS_RESET);
      lead_cpu     = '0;
      lead_score   = 0;
      self_listed  = 1'b0;
      open_request = 1'b0;
      expected_choices.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SMT_BIAS: smt_weight = cfg_data;
          CFG_LLC_BIAS: llc_weight = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fold_candidate(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_choices.size() == 0) begin
          $error("result transaction with no request waiting: chosen_cpu %0d, best_score %0d",
                 out_data.chosen_cpu, out_data.best_score);
          mismatches++;
        end else begin
          want = expected_choices.pop_front();
          if (out_data.chosen_cpu !== want.chosen_cpu) begin
            $error("chosen_cpu mismatch: expected %0d, actual %0d",
                   want.chosen_cpu, out_data.chosen_cpu);
            mismatches++;
          end
          if (out_data.best_score !== want.best_score) begin
            $error("best_score mismatch: expected %0d, actual %0d",
                   want.best_score, out_data.best_score);
            mismatches++;
          end
        end
      end
    end
    pending = expected_choices.size();
  end

endmodule

/* verif/tb.sv */
// Top of the fair wakeup CPU selector testbench: clock, reset, stimulus and verdict.
// Depends on fwcs_pkg, fair_wakeup_cpu_selector_core and cpu_choice_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwcs_pkg::*;

  // Wakeup flag masks, built from the bit positions in the package.
  localparam logic [FLAGS_W-1:0] F_TTWU   = FLAGS_W'(1 << WF_TTWU);
  localparam logic [FLAGS_W-1:0] F_EXEC   = FLAGS_W'(1 << WF_EXEC);
  localparam logic [FLAGS_W-1:0] F_SYNC   = FLAGS_W'(1 << WF_SYNC);
  localparam logic [FLAGS_W-1:0] F_AFFINE = FLAGS_W'(1 << WF_AFFINE);
  localparam logic [FLAGS_W-1:0] F_QUEUED = FLAGS_W'(1 << WF_QUEUED);
  localparam logic [FLAGS_W-1:0] F_LLC    = FLAGS_W'(1 << WF_LLC_KNOWN);
  localparam logic [LOC_W-1:0]   L_SMT    = LOC_W'(1 << LOC_SMT);
  localparam logic [LOC_W-1:0]   L_LLC    = LOC_W'(1 << LOC_LLC);

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 3000;
  localparam int RAND_CEIL    = (1 << UTIL_W) - 1;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BIAS_W-1:0]    cfg_data  = '0;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  int random_sent = 0;

  fair_wakeup_cpu_selector_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cpu_choice_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Load values cluster near zero so that many scores land around the busy margin,
  // while some use the full field width to reach the top bit.
  function automatic logic [UTIL_W-1:0] pick_load();
    case ($urandom_range(0, 9))
      0:       return UTIL_W'($urandom_range(0, RAND_CEIL));
      1, 2:    return '0;
      default: return UTIL_W'($urandom_range(0, 150));
    endcase
  endfunction

  function automatic logic [UTIL_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return UTIL_W'($urandom_range(0, RAND_CEIL));
      1:       return UTIL_W'($urandom_range(0, 200));
      default: return UTIL_W'($urandom_range(600, CAPACITY_SCALE));
    endcase
  endfunction

  // Most requests are short; a few run up to the full CPU count.
  function automatic int pick_request_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 6);
    if (roll < 95) return $urandom_range(7, 16);
    return $urandom_range(17, MAX_CPUS);
  endfunction

  function automatic logic [FLAGS_W-1:0] pick_flags();
    logic [FLAGS_W-1:0] fl;
    fl = FLAGS_W'($urandom_range(0, (1 << FLAGS_W) - 1));
    if ($urandom_range(0, 3) != 0) fl |= F_TTWU;
    return fl;
  endfunction

  function automatic in_item_t make_candidate(
      input int cpu, input int cap, input int cfs, input int rt, input int dl,
      input logic [LOC_W-1:0] loc, input int tutil, input int prev, input int self_cpu,
      input logic [FLAGS_W-1:0] fl, input logic closing);
    in_item_t c;
    c.cpu_id       = CPU_W'(cpu);
    c.cpu_capacity = UTIL_W'(cap);
    c.cfs_util     = UTIL_W'(cfs);
    c.rt_util      = UTIL_W'(rt);
    c.dl_util      = UTIL_W'(dl);
    c.locality     = loc;
    c.task_util    = UTIL_W'(tutil);
    c.prior_cpu    = CPU_W'(prev);
    c.waker_cpu    = CPU_W'(self_cpu);
    c.wake_bits    = fl;
    c.last         = closing;
    return c;
  endfunction

  // Presents one candidate after an optional idle gap and returns right after the
  // clock edge that accepts it. Valid stays high so a back-to-back transaction can
  // follow without a bubble. The ready line is looked at mid-cycle, where it is stable.
  task automatic send_candidate(input in_item_t c, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // A configuration write always ends with one cycle of valid low.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BIAS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the input side until every predicted result has come back, then lets the
  // pipeline empty out completely before the registers may be touched.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One wakeup request. A well-formed request keeps its task fields constant and
  // often lists the waking CPU and the previous CPU among the candidates; a noisy
  // one scrambles the per-request fields on every candidate.
  task automatic send_request(input int count, input bit noisy, input bit eager);
    int                 prev;
    int                 self_cpu;
    int                 tutil;
    int                 cpu;
    logic [FLAGS_W-1:0] fl;
    prev     = $urandom_range(0, MAX_CPUS - 1);
    self_cpu = $urandom_range(0, MAX_CPUS - 1);
    tutil    = pick_load();
    fl       = pick_flags();
    for (int i = 0; i < count; i++) begin
      if (noisy) begin
        prev     = $urandom_range(0, MAX_CPUS - 1);
        self_cpu = $urandom_range(0, MAX_CPUS - 1);
        tutil    = pick_load();
        fl       = pick_flags();
      end
      case ($urandom_range(0, 5))
        0:       cpu = self_cpu;
        1:       cpu = prev;
        default: cpu = $urandom_range(0, MAX_CPUS - 1);
      endcase
      send_candidate(make_candidate(cpu, pick_capacity(), pick_load(), pick_load(),
                                    pick_load(), LOC_W'($urandom_range(0, 3)), tutil,
                                    prev, self_cpu, fl, i == count - 1),
                     eager ? 0 : pick_gap());
      random_sent++;
    end
  endtask

  // Result side: runs of ready separated by stalls, with an occasional long
  // stretch of uninterrupted ready. Stalls are never empty, so
  // that ready is never lowered and raised within one step.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 20)) @(posedge clk);
      out_ready <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed candidates under the reset biases of four.
    // Empty score: nothing beats zero, so the default previous CPU stands.
    send_candidate(make_candidate(0, 0, 0, 0, 0, '0, 0, 5, 7, '0, 1'b1), 0);
    // Top CPU and capacity with all flags set, sync wakeup with the waking CPU listed.
    send_candidate(make_candidate(63, RAND_CEIL, 0, 0, 0, L_SMT | L_LLC, 0, 63, 63,
                                  '1, 1'b1), 1);
    // Heaviest loads everywhere: a deeply negative score.
    send_candidate(make_candidate(63, RAND_CEIL, RAND_CEIL, RAND_CEIL, RAND_CEIL,
                                  L_SMT | L_LLC, RAND_CEIL, 0, 0, '0, 1'b1), 0);
    // Affine bonus on the waking CPU for a try-to-wake-up wakeup.
    send_candidate(make_candidate(10, 900, 100, 0, 0, '0, 100, 3, 10, F_TTWU | F_AFFINE,
                                  1'b1), 0);
    // The affine bit alone, without a try-to-wake-up, earns nothing.
    send_candidate(make_candidate(3, 900, 100, 0, 0, '0, 100, 3, 10, F_AFFINE, 1'b1), 2);
    // SMT sibling bonus; then affine suppresses it while the LLC bonus still counts.
    send_candidate(make_candidate(12, 800, 0, 0, 0, L_SMT, 0, 3, 10, F_TTWU, 1'b1), 0);
    send_candidate(make_candidate(12, 800, 0, 0, 0, L_SMT | L_LLC, 0, 3, 10,
                                  F_TTWU | F_AFFINE | F_LLC, 1'b1), 0);
    // A queued task does not load its own previous CPU.
    send_candidate(make_candidate(3, 600, 100, 0, 0, '0, 400, 3, 10, F_TTWU | F_QUEUED,
                                  1'b0), 0);
    send_candidate(make_candidate(4, 600, 100, 0, 0, '0, 400, 3, 10, F_TTWU | F_QUEUED,
                                  1'b1), 0);
    // Exec wakeups get no bonus at all.
    send_candidate(make_candidate(5, 1000, 0, 0, 0, L_SMT | L_LLC, 0, 5, 5,
                                  F_TTWU | F_EXEC | F_LLC | F_AFFINE, 1'b1), 3);
    // Scores exactly at the busy margin and one below it.
    send_candidate(make_candidate(7, BUSY_MARGIN, 0, 0, 0, L_SMT | L_LLC, 0, 1, 2,
                                  F_TTWU | F_LLC, 1'b0), 0);
    send_candidate(make_candidate(8, 400, 0, 0, 0, L_SMT | L_LLC, 400 - BUSY_MARGIN + 1, 1,
                                  2, F_TTWU | F_LLC, 1'b1), 0);
    // Sync return with the waking CPU among the candidates, even though it scores lower.
    send_candidate(make_candidate(20, 1000, 0, 0, 0, '0, 0, 1, 21, F_TTWU | F_SYNC, 1'b0), 0);
    send_candidate(make_candidate(21, 100, 0, 0, 0, '0, 0, 1, 21, F_TTWU | F_SYNC, 1'b1), 0);
    // Sync without the waking CPU listed, and sync without a try-to-wake-up.
    send_candidate(make_candidate(20, 1000, 0, 0, 0, '0, 0, 1, 30, F_TTWU | F_SYNC, 1'b1), 0);
    send_candidate(make_candidate(21, 500, 0, 0, 0, '0, 0, 1, 21, F_SYNC, 1'b1), 1);
    // Per-request fields changing halfway: the default stays the first previous CPU.
    send_candidate(make_candidate(30, 600, 0, 0, 0, '0, 0, 40, 41, F_TTWU, 1'b0), 0);
    send_candidate(make_candidate(40, 700, 0, 0, 0, '0, 50, 41, 40,
                                  F_TTWU | F_QUEUED | F_SYNC, 1'b1), 0);
    // All candidates negative: default kept with score zero.
    send_candidate(make_candidate(1, 100, 200, 0, 0, '0, 0, 9, 2, F_TTWU, 1'b0), 0);
    send_candidate(make_candidate(2, 100, 50, 50, 50, '0, 0, 9, 2, F_TTWU, 1'b1), 0);
    // Equal scores: the first one listed keeps the lead.
    send_candidate(make_candidate(14, 700, 0, 0, 0, '0, 0, 9, 2, '0, 1'b0), 0);
    send_candidate(make_candidate(15, 700, 0, 0, 0, '0, 0, 9, 2, '0, 1'b1), 0);

    // Random phases, each under its own bias setting. Every phase boundary holds
    // the sender until all results are back, so the writes land on an idle block.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_SMT_BIAS, '0);
          write_reg(CFG_LLC_BIAS, '0);
        end
        1: begin
          write_reg(CFG_SMT_BIAS, BIAS_W'(BIAS_MAX));
          write_reg(CFG_LLC_BIAS, BIAS_W'(BIAS_MAX));
          write_reg(CFG_SPARE_A, BIAS_W'($urandom_range(0, 15)));
        end
        2: begin
          // Values above eight must behave as eight.
          write_reg(CFG_SMT_BIAS, '1);
          write_reg(CFG_LLC_BIAS, BIAS_W'(BIAS_MAX + 1));
          write_reg(CFG_SPARE_B, BIAS_W'($urandom_range(0, 15)));
        end
        default: begin
          write_reg(CFG_SMT_BIAS, BIAS_W'($urandom_range(0, 15)));
          write_reg(CFG_LLC_BIAS, BIAS_W'($urandom_range(0, 15)));
        end
      endcase
      while (random_sent < (ph + 1) * PHASE_ITEMS) begin
        send_request(pick_request_len(), $urandom_range(0, 9) == 0,
                     $urandom_range(0, 3) == 0);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
